>>> rtl/core/gsr_pkg.sv
// ----------------------------------------------------------------------------
// gsr_pkg: shared types and constants for the gear speed ramp controller
// Gear codes, gear characters, register indexes, field widths, reset values
// and the layout of the result word.
// ----------------------------------------------------------------------------
`default_nettype none

package gsr_pkg;

    // Decoded gear, as reported on the result stream
    typedef enum logic [1:0] {
        GEAR_NEUTRAL = 2'd0,
        GEAR_FIRST   = 2'd1,
        GEAR_SECOND  = 2'd2,
        GEAR_REVERSE = 2'd3
    } t_gear;

    // ASCII gear characters
    localparam logic [7:0] CHAR_FIRST   = 8'h31;  // '1'
    localparam logic [7:0] CHAR_SECOND  = 8'h32;  // '2'
    localparam logic [7:0] CHAR_REVERSE = 8'h52;  // 'R'
    localparam logic [7:0] CHAR_NEUTRAL = 8'h4E;  // 'N'

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_SPEED = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_SPEED    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FAST_RATE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_RATE    = 2'd3;

    // Field widths
    localparam int unsigned SPEED_INT_W = 10;
    localparam int unsigned RATE_W      = 16;
    localparam int unsigned RATE_FRAC_W = 16;
    localparam int unsigned CMD_MAG_W   = 7;
    localparam int unsigned CFG_DATA_W  = 16;
    localparam int unsigned IN_DATA_W   = 16;
    localparam int unsigned OUT_DATA_W  = 16;

    // Output word layout
    localparam int unsigned OUT_FWD_BIT  = 10;
    localparam int unsigned OUT_GEAR_LSB = 11;

    // Reset values and fixed limits
    localparam logic [SPEED_INT_W-1:0] RESET_LOWEST = 10'd650;
    localparam logic [SPEED_INT_W-1:0] RESET_TOP    = 10'd1000;
    localparam logic [SPEED_INT_W-1:0] RESET_SPEED  = 10'd1000;
    localparam logic [RATE_W-1:0]      RESET_FAST   = 16'd7646;
    localparam logic [RATE_W-1:0]      RESET_SLOW   = 16'd4588;
    localparam logic [CMD_MAG_W-1:0]   CMD_LIMIT    = 7'd100;
    localparam logic [CMD_MAG_W-1:0]   DECAY_UNITS  = 7'd100;

    // Reciprocal of three for an 11-bit sum: q = (s * 683) >> 11
    localparam int unsigned SUM_W       = 11;
    localparam logic [9:0]  RECIP_THREE = 10'd683;

endpackage

`default_nettype wire

>>> rtl/core/gear_speed_ramp_controller.sv
// ----------------------------------------------------------------------------
// gear_speed_ramp_controller: throttle and gear to PWM level and direction
// Keeps a fixed-point speed and a forward flag, ramps or decays the speed
// by gear rules each tick and reports the duty level and the direction.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) takes one control tick per request: throttle in
//   tdata[7:0], gear character in tdata[15:8]. Master stream (o_m_*) gives
//   one result per tick: PWM level, forward flag and decoded gear code.
//   The configuration port writes floor, top speed and the two ramp rates;
//   write it only while no tick is in flight.
//   Path: an accepted tick waits in the input register, and its result is
//   then loaded into the result register, from which the receiver takes
//   it (input register, then result register).
//   Throughput: one tick per cycle while the receiver does not stall. The
//   speed update (one 16x7 multiply, one add or subtract and the cap compares)
//   is combinational from the speed register back to itself, setting this rate.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more tick; after that o_s_tready drops.
//   Reset empties both registers, restores the register defaults, sets the
//   speed to 1000 and the direction to forward.
// ----------------------------------------------------------------------------
`default_nettype none

module gear_speed_ramp_controller #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Configuration write port
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [gsr_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [gsr_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // Tick stream in
    input  wire logic                                i_s_tvalid,
    output      logic                                o_s_tready,
    input  wire logic [gsr_pkg::IN_DATA_W-1:0]       i_s_tdata,  // throttle[7:0], gear_char[15:8]
    // Result stream out
    output      logic                                o_m_tvalid,
    input  wire logic                                i_m_tready,
    output      logic [gsr_pkg::OUT_DATA_W-1:0]      o_m_tdata   // pwm_level[9:0], forward[10],
                                                                 // gear_code[12:11], zero[15:13]
);

    localparam int unsigned SW   = gsr_pkg::SPEED_INT_W + FRACTION_BITS;
    localparam int unsigned PW   = gsr_pkg::RATE_W + gsr_pkg::CMD_MAG_W;
    localparam int unsigned XW   = PW + FRACTION_BITS;
    localparam logic [FRACTION_BITS-1:0] THIRD_ONE = FRACTION_BITS'((2 ** FRACTION_BITS) / 3);
    localparam logic [FRACTION_BITS-1:0] THIRD_TWO =
        FRACTION_BITS'((2 ** (FRACTION_BITS + 1)) / 3);

    typedef enum logic [1:0] {
        OP_HOLD  = 2'd0,
        OP_DECAY = 2'd1,
        OP_RAMP  = 2'd2
    } t_op;

    // Configuration registers
    logic [gsr_pkg::SPEED_INT_W-1:0] r_lowest;
    logic [gsr_pkg::SPEED_INT_W-1:0] r_top;
    logic [gsr_pkg::RATE_W-1:0]      r_fast;
    logic [gsr_pkg::RATE_W-1:0]      r_slow;

    // Pipeline registers and state
    logic                            r_in_valid;
    logic [7:0]                      r_in_throttle;
    logic [7:0]                      r_in_gear_char;
    logic                            r_out_valid;
    logic [gsr_pkg::SPEED_INT_W-1:0] r_out_pwm;
    logic                            r_out_fwd;
    gsr_pkg::t_gear                  r_out_gear;
    logic [SW-1:0]                   r_speed;
    logic                            r_fwd;

    logic                            advance;
    logic                            in_accept;

    // Per-tick datapath
    logic                            cmd_neg;
    logic [7:0]                      cmd_abs;
    logic [gsr_pkg::CMD_MAG_W-1:0]   cmd_mag;
    gsr_pkg::t_gear                  gear;
    logic [SW-1:0]                   floor_fx;
    logic [gsr_pkg::SUM_W-1:0]       sum_int;
    logic [SW-1:0]                   cap_first;
    logic [SW-1:0]                   cap_top;
    logic [SW-1:0]                   cap_rev;
    logic [20:0]                     third_prod;
    logic [9:0]                      third_q;
    logic [gsr_pkg::SUM_W-1:0]       third_r;
    logic [FRACTION_BITS-1:0]        third_frac;
    t_op                             op;
    logic [SW-1:0]                   cap;
    logic                            use_slow;
    logic                            n_fwd;
    logic [gsr_pkg::RATE_W-1:0]      rate;
    logic [gsr_pkg::CMD_MAG_W-1:0]   units;
    logic [PW-1:0]                   prod;
    logic [XW-1:0]                   prod_wide;
    logic [SW-1:0]                   step;
    logic [SW:0]                     speed_up;
    logic [SW-1:0]                   speed_down;
    logic [SW-1:0]                   speed_ramp;
    logic [SW-1:0]                   speed_gear;
    logic [SW-1:0]                   n_speed;
    logic [gsr_pkg::SPEED_INT_W-1:0] n_pwm;

    // Handshake: the input register moves on whenever the result register frees
    assign advance    = ~r_out_valid | i_m_tready;
    assign o_s_tready = ~r_in_valid | advance;
    assign in_accept  = i_s_tvalid & o_s_tready;

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {3'b000, r_out_gear, r_out_fwd, r_out_pwm};

    // Saturate the throttle to +-100 as sign and magnitude
    always_comb begin
        cmd_neg = r_in_throttle[7];
        cmd_abs = cmd_neg ? (~r_in_throttle + 8'd1) : r_in_throttle;
        cmd_mag = (cmd_abs > 8'(gsr_pkg::CMD_LIMIT)) ? gsr_pkg::CMD_LIMIT
                                                      : cmd_abs[gsr_pkg::CMD_MAG_W-1:0];
    end

    // Decode the gear character; anything unknown is neutral
    always_comb begin
        unique case (r_in_gear_char)
            gsr_pkg::CHAR_FIRST:   gear = gsr_pkg::GEAR_FIRST;
            gsr_pkg::CHAR_SECOND:  gear = gsr_pkg::GEAR_SECOND;
            gsr_pkg::CHAR_REVERSE: gear = gsr_pkg::GEAR_REVERSE;
            gsr_pkg::CHAR_NEUTRAL: gear = gsr_pkg::GEAR_NEUTRAL;
            default:               gear = gsr_pkg::GEAR_NEUTRAL;
        endcase
    end

    // Floor and caps in fixed point; reverse cap is (top+lowest)/3 via reciprocal
    always_comb begin
        floor_fx   = {r_lowest, FRACTION_BITS'(0)};
        sum_int    = {1'b0, r_top} + {1'b0, r_lowest};
        cap_first  = SW'({sum_int, FRACTION_BITS'(0)} >> 1);
        cap_top    = {r_top, FRACTION_BITS'(0)};
        third_prod = sum_int * gsr_pkg::RECIP_THREE;
        third_q    = third_prod[20:11];
        third_r    = sum_int - 11'(third_q * 2'd3);
        case (third_r[1:0])
            2'd1:    third_frac = THIRD_ONE;
            2'd2:    third_frac = THIRD_TWO;
            default: third_frac = '0;
        endcase
        cap_rev    = {third_q, FRACTION_BITS'(0)} + SW'(third_frac);
    end

    // Pick the operation, cap, rate and direction for this tick
    always_comb begin
        op       = OP_HOLD;
        cap      = cap_top;
        n_fwd    = r_fwd;
        use_slow = (gear == gsr_pkg::GEAR_FIRST) || (gear == gsr_pkg::GEAR_REVERSE);
        case (gear) inside
            gsr_pkg::GEAR_FIRST, gsr_pkg::GEAR_SECOND: begin
                if (!r_fwd) begin
                    if (r_speed > floor_fx) op = OP_DECAY;
                    else n_fwd = 1'b1;
                end else if (gear == gsr_pkg::GEAR_FIRST) begin
                    cap = cap_first;
                    op  = (r_speed > cap_first) ? OP_DECAY : OP_RAMP;
                end else begin
                    op = OP_RAMP;
                end
            end
            gsr_pkg::GEAR_REVERSE: begin
                if (r_fwd) begin
                    if (r_speed > floor_fx) op = OP_DECAY;
                    else n_fwd = 1'b0;
                end else begin
                    cap = cap_rev;
                    op  = OP_RAMP;
                end
            end
            default: begin
                if (r_speed > floor_fx) op = OP_DECAY;
            end
        endcase
    end

    // Step = rate * units, rescaled from Q0.16 to the speed fraction
    always_comb begin
        rate      = use_slow ? r_slow : r_fast;
        units     = (op == OP_DECAY) ? gsr_pkg::DECAY_UNITS : cmd_mag;
        prod      = rate * units;
        prod_wide = (XW'(prod) << FRACTION_BITS) >> gsr_pkg::RATE_FRAC_W;
        step      = prod_wide[SW-1:0];
    end

    // Apply the step, the cap clamp and the floor rule
    always_comb begin
        speed_up   = {1'b0, r_speed} + {1'b0, step};
        speed_down = (step > r_speed) ? '0 : (r_speed - step);
        speed_ramp = r_speed;
        if (r_speed < cap) begin
            if (cmd_neg) speed_ramp = speed_down;
            else if (speed_up >= {1'b0, cap}) speed_ramp = cap;
            else speed_ramp = speed_up[SW-1:0];
        end
        if (speed_ramp >= cap) speed_ramp = cap;

        case (op)
            OP_DECAY: speed_gear = speed_down;
            OP_RAMP:  speed_gear = speed_ramp;
            default:  speed_gear = r_speed;
        endcase

        if (speed_gear < floor_fx) begin
            n_speed = floor_fx;
            n_pwm   = '0;
        end else begin
            n_speed = speed_gear;
            n_pwm   = speed_gear[SW-1:FRACTION_BITS];
        end
    end

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lowest <= gsr_pkg::RESET_LOWEST;
            r_top    <= gsr_pkg::RESET_TOP;
            r_fast   <= gsr_pkg::RESET_FAST;
            r_slow   <= gsr_pkg::RESET_SLOW;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                gsr_pkg::CFG_LOWEST_SPEED: r_lowest <= i_cfg_data[gsr_pkg::SPEED_INT_W-1:0];
                gsr_pkg::CFG_TOP_SPEED:    r_top    <= i_cfg_data[gsr_pkg::SPEED_INT_W-1:0];
                gsr_pkg::CFG_FAST_RATE:    r_fast   <= i_cfg_data;
                gsr_pkg::CFG_SLOW_RATE:    r_slow   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Control: valid flags, speed and direction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_speed     <= {gsr_pkg::RESET_SPEED, FRACTION_BITS'(0)};
            r_fwd       <= 1'b1;
        end else begin
            if (in_accept) r_in_valid <= 1'b1;
            else if (advance) r_in_valid <= 1'b0;
            if (advance) begin
                r_out_valid <= r_in_valid;
                if (r_in_valid) begin
                    r_speed <= n_speed;
                    r_fwd   <= n_fwd;
                end
            end
        end
    end

    // Payload: hold the request, load the result
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_throttle  <= i_s_tdata[7:0];
            r_in_gear_char <= i_s_tdata[15:8];
        end
        if (advance && r_in_valid) begin
            r_out_pwm  <= n_pwm;
            r_out_fwd  <= n_fwd;
            r_out_gear <= gear;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/gsr_checker.sv
// ----------------------------------------------------------------------------
// gsr_checker: port-level checks for the gear speed ramp controller
// Watches the stream ports over time and flags handshake, reset,
// direction-change and padding slips.
// ----------------------------------------------------------------------------
`default_nettype none

module gsr_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           o_s_tready,
    input wire logic                           o_m_tvalid,
    input wire logic                           i_m_tready,
    input wire logic [gsr_pkg::OUT_DATA_W-1:0] o_m_tdata
);

    logic       r_have_prev;
    logic       r_prev_fwd;
    logic       out_accept;
    logic       cur_fwd;
    logic [1:0] cur_gear;

    assign out_accept = o_m_tvalid & i_m_tready;
    assign cur_fwd    = o_m_tdata[gsr_pkg::OUT_FWD_BIT];
    assign cur_gear   = o_m_tdata[gsr_pkg::OUT_GEAR_LSB +: 2];

    // Track the direction of the last delivered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have_prev <= 1'b0;
            r_prev_fwd  <= 1'b1;
        end else if (out_accept) begin
            r_have_prev <= 1'b1;
            r_prev_fwd  <= cur_fwd;
        end
    end

    // Stalled result holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // Reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid right after reset");

    // An empty result register never blocks new requests
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result register");

    // Direction flips only toward the gear that asks for it
    a_flip_by_gear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_accept && r_have_prev && (cur_fwd != r_prev_fwd) |->
            (cur_fwd  && (cur_gear == gsr_pkg::GEAR_FIRST || cur_gear == gsr_pkg::GEAR_SECOND)) ||
            (!cur_fwd && (cur_gear == gsr_pkg::GEAR_REVERSE)))
        else $error("direction flipped without a matching gear");

    // Padding bits of the result word stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[gsr_pkg::OUT_DATA_W-1:gsr_pkg::OUT_GEAR_LSB+2] == '0))
        else $error("result padding not zero");

endmodule

bind gear_speed_ramp_controller gsr_checker u_gsr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);

`default_nettype wire

>>> test/gear_speed_ramp_controller_tb.sv
// ----------------------------------------------------------------------------
// gear_speed_ramp_controller_tb: self-checking bench for the ramp controller
// Streams throttle and gear ticks into the block and checks every PWM level,
// direction and gear code against an in-bench model of the speed ramp. A
// short directed table comes first, then runs of random ticks under several
// register settings and idle patterns on both streams.
// ----------------------------------------------------------------------------
module gear_speed_ramp_controller_tb;

    localparam int SPEED_FRAC    = 16;
    localparam int PHASES        = 9;
    localparam int PHASE_ITEMS   = 92;
    localparam int STALL_LIMIT   = 5000;
    localparam int DIRECTED_ROWS = 26;
    localparam int FLOOR_ROW     = 21;

    // One result: PWM level, direction, decoded gear
    typedef struct packed {
        logic [gsr_pkg::SPEED_INT_W-1:0] pwm;
        logic                            fwd;
        gsr_pkg::t_gear                  gear;
    } t_tick_result;

    // Register set for one phase
    typedef struct packed {
        logic [gsr_pkg::SPEED_INT_W-1:0] lowest;
        logic [gsr_pkg::SPEED_INT_W-1:0] top;
        logic [gsr_pkg::RATE_W-1:0]      fast;
        logic [gsr_pkg::RATE_W-1:0]      slow;
    } t_ramp_cfg;

    // Directed tick, with a typed result where it is obvious
    typedef struct packed {
        logic [7:0]   thr;
        logic [7:0]   gch;
        logic         typed;
        t_tick_result res;
    } t_directed_row;

    localparam t_tick_result NO_RES = '{10'd0, 1'b0, gsr_pkg::GEAR_NEUTRAL};

    logic                             i_clk;
    logic                             i_rst_n;
    logic                             i_cfg_wr_en;
    logic [gsr_pkg::CFG_IDX_W-1:0]    i_cfg_index;
    logic [gsr_pkg::CFG_DATA_W-1:0]   i_cfg_data;
    logic                             i_s_tvalid;
    logic                             o_s_tready;
    logic [gsr_pkg::IN_DATA_W-1:0]    i_s_tdata;   // throttle[7:0], gear_char[15:8]
    logic                             o_m_tvalid;
    logic                             i_m_tready = 1'b0;
    logic [gsr_pkg::OUT_DATA_W-1:0]   o_m_tdata;   // pwm_level[9:0], forward[10], gear_code[12:11]

    // Model state and register mirror
    longint unsigned                  speed_q;
    bit                               going_fwd;
    logic [gsr_pkg::SPEED_INT_W-1:0]  floor_reg;
    logic [gsr_pkg::SPEED_INT_W-1:0]  top_reg;
    logic [gsr_pkg::RATE_W-1:0]       fast_reg;
    logic [gsr_pkg::RATE_W-1:0]       slow_reg;

    t_tick_result                     expected_drive_q[$];
    int                               send_idle_pct;
    int                               recv_idle_pct;
    int                               stall_cycles = 0;
    bit                               failed = 1'b0;

    t_directed_row tick_rows [DIRECTED_ROWS] = '{
        '{8'd100, gsr_pkg::CHAR_SECOND,  1'b1, '{10'd1000, 1'b1, gsr_pkg::GEAR_SECOND}},
        '{8'h7F,  gsr_pkg::CHAR_SECOND,  1'b1,
          '{10'd1000, 1'b1, gsr_pkg::GEAR_SECOND}},                     // +127 saturates
        '{8'h80,  gsr_pkg::CHAR_SECOND,  1'b1,
          '{10'd1000, 1'b1, gsr_pkg::GEAR_SECOND}},                     // -128 at the cap
        '{8'd0,   gsr_pkg::CHAR_NEUTRAL, 1'b0, NO_RES},
        '{8'h9C,  gsr_pkg::CHAR_SECOND,  1'b0, NO_RES},                 // -100 brakes
        '{8'h65,  gsr_pkg::CHAR_FIRST,   1'b0, NO_RES},                 // +101 saturates
        '{8'd1,   gsr_pkg::CHAR_FIRST,   1'b0, NO_RES},
        '{8'hFF,  gsr_pkg::CHAR_FIRST,   1'b0, NO_RES},
        '{8'h9B,  gsr_pkg::CHAR_SECOND,  1'b0, NO_RES},                 // -101 saturates
        '{8'd0,   8'h00,                 1'b0, NO_RES},                 // unknown gears
        '{8'd50,  8'hFF,                 1'b0, NO_RES},
        '{8'd100, 8'h72,                 1'b0, NO_RES},
        '{8'd0,   gsr_pkg::CHAR_REVERSE, 1'b0, NO_RES},
        '{8'd100, gsr_pkg::CHAR_REVERSE, 1'b0, NO_RES},
        '{8'h80,  gsr_pkg::CHAR_REVERSE, 1'b0, NO_RES},
        '{8'd0,   gsr_pkg::CHAR_FIRST,   1'b0, NO_RES},
        '{8'd100, 8'h30,                 1'b0, NO_RES},
        '{8'd100, gsr_pkg::CHAR_SECOND,  1'b0, NO_RES},
        '{8'h7F,  gsr_pkg::CHAR_NEUTRAL, 1'b0, NO_RES},
        '{8'h80,  gsr_pkg::CHAR_NEUTRAL, 1'b0, NO_RES},
        '{8'd100, gsr_pkg::CHAR_FIRST,   1'b0, NO_RES},
        // floor raised to 1023: direction flips, reverse cap lies below the floor
        '{8'd0,   gsr_pkg::CHAR_REVERSE, 1'b1, '{10'd0, 1'b0, gsr_pkg::GEAR_REVERSE}},
        '{8'd100, gsr_pkg::CHAR_REVERSE, 1'b1, '{10'd0, 1'b0, gsr_pkg::GEAR_REVERSE}},
        '{8'd0,   gsr_pkg::CHAR_FIRST,   1'b0, NO_RES},
        '{8'd100, gsr_pkg::CHAR_SECOND,  1'b0, NO_RES},
        '{8'h80,  gsr_pkg::CHAR_NEUTRAL, 1'b0, NO_RES}
    };

    gear_speed_ramp_controller #(
        .FRACTION_BITS(SPEED_FRAC)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Ramp step in Q.F from a Q0.16 rate and a whole number of command units
    function automatic longint unsigned ramp_step(longint unsigned rate,
                                                  longint unsigned units);
        return ((rate * units) << SPEED_FRAC) >> gsr_pkg::RATE_FRAC_W;
    endfunction

    function automatic longint unsigned sub_clamp(longint unsigned a, longint unsigned b);
        return (b > a) ? 64'd0 : a - b;
    endfunction

    // Ramp toward a cap, then clamp at it
    function automatic void ramp_toward(longint unsigned cap, longint unsigned rate, int cmd);
        if (speed_q < cap) begin
            if (cmd >= 0)
                speed_q = speed_q + ramp_step(rate, cmd);
            else
                speed_q = sub_clamp(speed_q, ramp_step(rate, -cmd));
        end
        if (speed_q >= cap)
            speed_q = cap;
    endfunction

    // Advance the model speed by one tick and return the drive it reports
    function automatic t_tick_result advance_speed(logic [7:0] thr, logic [7:0] gch);
        int              cmd;
        gsr_pkg::t_gear  gear;
        longint unsigned floor_fx;
        longint unsigned sum_fx;
        longint unsigned rate;
        t_tick_result    res;
        cmd = $signed(thr);
        if (cmd > int'(gsr_pkg::CMD_LIMIT))
            cmd = int'(gsr_pkg::CMD_LIMIT);
        if (cmd < -int'(gsr_pkg::CMD_LIMIT))
            cmd = -int'(gsr_pkg::CMD_LIMIT);
        case (gch)
            gsr_pkg::CHAR_FIRST:   gear = gsr_pkg::GEAR_FIRST;
            gsr_pkg::CHAR_SECOND:  gear = gsr_pkg::GEAR_SECOND;
            gsr_pkg::CHAR_REVERSE: gear = gsr_pkg::GEAR_REVERSE;
            default:               gear = gsr_pkg::GEAR_NEUTRAL;
        endcase
        floor_fx = 64'(floor_reg) << SPEED_FRAC;
        sum_fx   = (64'(top_reg) + 64'(floor_reg)) << SPEED_FRAC;
        case (gear) inside
            gsr_pkg::GEAR_FIRST, gsr_pkg::GEAR_SECOND: begin
                rate = (gear == gsr_pkg::GEAR_FIRST) ? 64'(slow_reg) : 64'(fast_reg);
                if (!going_fwd) begin
                    // decay to the floor before turning forward
                    if (speed_q > floor_fx)
                        speed_q = sub_clamp(speed_q, ramp_step(rate, gsr_pkg::DECAY_UNITS));
                    else
                        going_fwd = 1'b1;
                end else if (gear == gsr_pkg::GEAR_FIRST) begin
                    if (speed_q > sum_fx / 2)
                        speed_q = sub_clamp(speed_q, ramp_step(rate, gsr_pkg::DECAY_UNITS));
                    else
                        ramp_toward(sum_fx / 2, rate, cmd);
                end else begin
                    ramp_toward(64'(top_reg) << SPEED_FRAC, rate, cmd);
                end
            end
            gsr_pkg::GEAR_REVERSE: begin
                if (going_fwd) begin
                    if (speed_q > floor_fx)
                        speed_q = sub_clamp(speed_q,
                                            ramp_step(slow_reg, gsr_pkg::DECAY_UNITS));
                    else
                        going_fwd = 1'b0;
                end else begin
                    ramp_toward(sum_fx / 3, slow_reg, cmd);
                end
            end
            default: begin
                if (speed_q > floor_fx)
                    speed_q = sub_clamp(speed_q, ramp_step(fast_reg, gsr_pkg::DECAY_UNITS));
            end
        endcase
        // Hold the floor; below it the drive is zero
        if (speed_q < floor_fx) begin
            speed_q = floor_fx;
            res.pwm = '0;
        end else begin
            res.pwm = gsr_pkg::SPEED_INT_W'(speed_q >> SPEED_FRAC);
        end
        res.fwd  = going_fwd;
        res.gear = gear;
        return res;
    endfunction

    // Send one tick request, with random idle cycles ahead of it
    task automatic push_tick(input logic [7:0] thr, input logic [7:0] gch,
                             input logic typed, input t_tick_result typed_res);
        t_tick_result res;
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {gch, thr};
        @(posedge i_clk);
        while (!o_s_tready)
            @(posedge i_clk);
        res = advance_speed(thr, gch);
        expected_drive_q.push_back(typed ? typed_res : res);
    endtask

    // Drop the request line and wait until every result is back
    task automatic wait_idle();
        i_s_tvalid <= 1'b0;
        while (expected_drive_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [gsr_pkg::CFG_IDX_W-1:0] idx,
                             input logic [gsr_pkg::CFG_DATA_W-1:0] data);
        i_cfg_wr_en <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
    endtask

    // Write all four registers and mirror them in the model
    task automatic load_regs(input t_ramp_cfg cfg);
        write_reg(gsr_pkg::CFG_LOWEST_SPEED, gsr_pkg::CFG_DATA_W'(cfg.lowest));
        write_reg(gsr_pkg::CFG_TOP_SPEED, gsr_pkg::CFG_DATA_W'(cfg.top));
        write_reg(gsr_pkg::CFG_FAST_RATE, cfg.fast);
        write_reg(gsr_pkg::CFG_SLOW_RATE, cfg.slow);
        i_cfg_wr_en <= 1'b0;
        floor_reg = cfg.lowest;
        top_reg   = cfg.top;
        fast_reg  = cfg.fast;
        slow_reg  = cfg.slow;
    endtask

    // Stall the result stream at random and check each accepted result
    always @(posedge i_clk) begin : check_drive
        t_tick_result want;
        i_m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_drive_q.size() == 0) begin
                $display("%0t: unexpected result, expected none, got tdata %h",
                         $time, o_m_tdata);
                failed = 1'b1;
            end else begin
                want = expected_drive_q.pop_front();
                if (o_m_tdata[gsr_pkg::SPEED_INT_W-1:0] !== want.pwm) begin
                    $display("%0t: pwm_level expected %0d, got %0d",
                             $time, want.pwm, o_m_tdata[gsr_pkg::SPEED_INT_W-1:0]);
                    failed = 1'b1;
                end
                if (o_m_tdata[gsr_pkg::OUT_FWD_BIT] !== want.fwd) begin
                    $display("%0t: forward expected %0b, got %0b",
                             $time, want.fwd, o_m_tdata[gsr_pkg::OUT_FWD_BIT]);
                    failed = 1'b1;
                end
                if (o_m_tdata[gsr_pkg::OUT_GEAR_LSB +: 2] !== want.gear) begin
                    $display("%0t: gear_code expected %0d, got %0d",
                             $time, want.gear, o_m_tdata[gsr_pkg::OUT_GEAR_LSB +: 2]);
                    failed = 1'b1;
                end
            end
        end
    end

    // Count cycles in which neither stream moves a request
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT)
            @(posedge i_clk);
        $display("** gear_speed_ramp_controller: FAILED **");
        $finish;
    end

    initial begin : stimulus
        int         i;
        int         p;
        int         n;
        int         k;
        int         run_len;
        logic [7:0] thr;
        logic [7:0] gch;
        t_ramp_cfg  cfg;
        i_rst_n     <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_index <= gsr_pkg::CFG_LOWEST_SPEED;
        i_cfg_data  <= '0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        send_idle_pct = 31;
        recv_idle_pct = 73;
        // Model reset state
        speed_q   = 64'(gsr_pkg::RESET_SPEED) << SPEED_FRAC;
        going_fwd = 1'b1;
        floor_reg = gsr_pkg::RESET_LOWEST;
        top_reg   = gsr_pkg::RESET_TOP;
        fast_reg  = gsr_pkg::RESET_FAST;
        slow_reg  = gsr_pkg::RESET_SLOW;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table at the reset settings, the tail with the floor raised
        for (i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == FLOOR_ROW) begin
                wait_idle();
                cfg = '{10'd1023, gsr_pkg::RESET_TOP, gsr_pkg::RESET_FAST,
                        gsr_pkg::RESET_SLOW};
                load_regs(cfg);
            end
            push_tick(tick_rows[i].thr, tick_rows[i].gch, tick_rows[i].typed, tick_rows[i].res);
        end

        // Random runs of one gear, with noise ticks between them
        for (p = 0; p < PHASES; p++) begin
            wait_idle();
            case (p)
                0: cfg = '{gsr_pkg::RESET_LOWEST, gsr_pkg::RESET_TOP, gsr_pkg::RESET_FAST,
                           gsr_pkg::RESET_SLOW};
                1: cfg = '{10'd0, 10'd1023, 16'hFFFF, 16'hFFFF};
                2: cfg = '{10'd1023, 10'd0, 16'd0, 16'd0};
                3: cfg = '{10'd100, 10'd1023, 16'd3000, 16'd9000};
                8: cfg = '{10'($urandom), 10'($urandom), 16'($urandom), 16'($urandom)};
                default: cfg = '{10'($urandom_range(0, 300)), 10'($urandom_range(600, 1023)),
                                 16'($urandom_range(1000, 20000)),
                                 16'($urandom_range(1000, 20000))};
            endcase
            load_regs(cfg);
            send_idle_pct = (p < 3) ? 31 : (p < 6) ? 73 : 0;
            recv_idle_pct = (p < 3) ? 73 : (p < 6) ? 31 : 0;
            n = 0;
            while (n < PHASE_ITEMS) begin
                if ($urandom_range(0, 9) == 0) begin
                    push_tick(8'($urandom), 8'($urandom), 1'b0, NO_RES);
                    n++;
                end else begin
                    case ($urandom_range(0, 3))
                        0:       gch = gsr_pkg::CHAR_NEUTRAL;
                        1:       gch = gsr_pkg::CHAR_FIRST;
                        2:       gch = gsr_pkg::CHAR_SECOND;
                        default: gch = gsr_pkg::CHAR_REVERSE;
                    endcase
                    run_len = $urandom_range(1, 40);
                    if (run_len > PHASE_ITEMS - n)
                        run_len = PHASE_ITEMS - n;
                    for (k = 0; k < run_len; k++) begin
                        if ($urandom_range(0, 7) == 0)
                            thr = 8'($urandom);
                        else
                            thr = 8'(int'($urandom_range(0, 200)) - 100);
                        push_tick(thr, gch, 1'b0, NO_RES);
                    end
                    n += run_len;
                end
            end
        end

        wait_idle();
        if (!failed)
            $display("** gear_speed_ramp_controller: PASSED **");
        else
            $display("** gear_speed_ramp_controller: FAILED **");
        $finish;
    end

endmodule
